[rtl/npk_pkg.sv]
// Package: constants and the base-coding function for the nucleotide packer.
package npk_pkg;

	localparam int unsigned SymW      = 8;
	localparam int unsigned CodeW     = 2;
	localparam int unsigned CountW    = 32;
	localparam int unsigned GroupSize = 32;
	localparam int unsigned GroupBits = $clog2(GroupSize);
	localparam int unsigned IndexW    = CountW - GroupBits;
	localparam int unsigned ExcW      = GroupSize;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned DataW     = ByteW + ExcW + IndexW;
	localparam int unsigned TdataW    = ((DataW + 7) / 8) * 8;
	localparam int unsigned UserW     = 2;

	localparam logic [SymW-1:0] FoldMask = 8'hDF;
	localparam logic [SymW-1:0] ChA      = 8'h41;
	localparam logic [SymW-1:0] ChC      = 8'h43;
	localparam logic [SymW-1:0] ChG      = 8'h47;
	localparam logic [SymW-1:0] ChT      = 8'h54;

	localparam logic [CodeW-1:0] CodeA = 2'd0;
	localparam logic [CodeW-1:0] CodeC = 2'd1;
	localparam logic [CodeW-1:0] CodeG = 2'd2;
	localparam logic [CodeW-1:0] CodeT = 2'd3;

	typedef struct packed {
		logic             exc;
		logic [CodeW-1:0] code;
	} base_t;

	function automatic base_t encode_base(input logic [SymW-1:0] sym);
		logic [SymW-1:0] ch;
		base_t           b;
		ch = sym & FoldMask;
		b.exc = 1'b0;
		unique case (ch)
			ChA:     b.code = CodeA;
			ChC:     b.code = CodeC;
			ChG:     b.code = CodeG;
			ChT:     b.code = CodeT;
			default: begin
				b.code = CodeA;
				b.exc  = 1'b1;
			end
		endcase
		return b;
	endfunction

endpackage

[rtl/nucleotide_packer_with_exception_mask.sv]
// Top level: 2-bit nucleotide packer with a 32-symbol exception mask.
//
// Input stream (s_axis): one character per word in s_axis_tdata[7:0]. Case is
// folded; A/C/G/T code as 0..3, anything else codes as 0 and flags an exception.
// Output stream (m_axis): one word per four symbols. tdata carries the packed
// byte (earliest base in bits 7:6), the 32-bit exception word (earliest symbol
// in bit 31) and the 27-bit group index. tuser[0] marks the packed byte,
// tuser[1] marks a nonzero exception word, sent on every 32nd symbol only.
//
// Order: the fourth symbol of a byte is registered at acceptance; the result
// register loads from the input register once no result is held unread.
// Throughput: one symbol per cycle unless a completing symbol waits; the state
// update is a shift and a 32-bit increment between input and result registers.
// Stall: a symbol that completes no byte never waits; a completing symbol waits
// in the input register while a result is held unread, and s_axis_tready drops.
// Reset: the counter, partial codes and exception bits clear, both
// stages empty.
module nucleotide_packer_with_exception_mask
	import npk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [SymW-1:0]   s_axis_tdata,   // [7:0] symbol
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [TdataW-1:0] m_axis_tdata,   // [7:0] packed_byte, [39:8] exception_word,
	                                          // [66:40] word_index, rest zero
	output logic [UserW-1:0]  m_axis_tuser    // [0] byte_valid, [1] word_valid
);

	logic              valid_s1;
	logic [SymW-1:0]   symbol_s1;
	logic [5:0]        partial_q;
	logic [ExcW-2:0]   exc_bits_q;
	logic [CountW-1:0] count_q;

	logic              out_valid_q;
	logic [ByteW-1:0]  byte_q;
	logic              word_valid_q;
	logic [ExcW-1:0]   exc_word_q;
	logic [IndexW-1:0] index_q;

	base_t             base;
	logic [ByteW-1:0]  codes;
	logic [ExcW-1:0]   bits;
	logic              byte_done;
	logic              word_done;
	logic              advance;
	logic              out_free;

	always_comb begin
		base      = encode_base(symbol_s1);
		codes     = {partial_q, base.code};
		bits      = {exc_bits_q, base.exc};
		byte_done = (count_q[1:0] == 2'b11);
		word_done = (count_q[GroupBits-1:0] == {GroupBits{1'b1}});
		out_free  = !out_valid_q || m_axis_tready;
		advance   = valid_s1 && (!byte_done || out_free);
	end

	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			symbol_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			exc_bits_q <= '0;
			count_q    <= '0;
		end else if (advance) begin
			count_q    <= count_q + CountW'(1);
			partial_q  <= byte_done ? 6'd0 : codes[5:0];
			exc_bits_q <= word_done ? '0 : bits[ExcW-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && byte_done;
		end
	end

	// zero the exception fields unless this closes a group with exceptions
	always_ff @(posedge clk) begin
		if (out_free && advance && byte_done) begin
			byte_q <= codes;
			if (word_done && (bits != '0)) begin
				word_valid_q <= 1'b1;
				exc_word_q   <= bits;
				index_q      <= count_q[CountW-1:GroupBits];
			end else begin
				word_valid_q <= 1'b0;
				exc_word_q   <= '0;
				index_q      <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TdataW-DataW){1'b0}}, index_q, exc_word_q, byte_q};
	assign m_axis_tuser  = {word_valid_q, 1'b1};

endmodule

[rtl/npk_checker.sv]
// Checker: port-level properties of the nucleotide packer, bound to the top level.
module npk_checker
	import npk_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [TdataW-1:0] m_axis_tdata,
	input logic [UserW-1:0]  m_axis_tuser
);

	// handshake lines are always driven out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready}))
		else $error("handshake line unknown");

	// every result word carries a packed byte
	a_byte_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0])
		else $error("result word without byte flag");

	// no exception word: exception and index fields are zero
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[TdataW-1:ByteW] == '0))
		else $error("exception fields set without word flag");

	// a flagged exception word is never empty
	a_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[ByteW+ExcW-1:ByteW] != '0))
		else $error("empty exception word flagged");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind nucleotide_packer_with_exception_mask npk_checker u_npk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[tb/sv/nucleotide_packer_with_exception_mask_tb.sv]
// Self-checking testbench for the 2-bit nucleotide packer with exception mask.
`timescale 1ns / 100ps

module nucleotide_packer_with_exception_mask_tb;
	import npk_pkg::*;

	localparam int unsigned DirRows      = 24;
	localparam int unsigned RandPerPhase = 500;
	localparam int unsigned HoldCycles   = 400;
	localparam int unsigned StuckLimit   = 4000;
	localparam int unsigned MaxReports   = 10;
	localparam int unsigned DrainCycles  = 8;

	localparam logic [SymW-1:0] LowerBit = 8'h20;
	localparam logic [SymW-1:0] HighBit  = 8'h80;

	typedef enum logic [1:0] {GRP_CLEAN, GRP_SPARSE, GRP_NOISE} group_mode_t;

	typedef struct packed {
		logic              word_valid;
		logic              byte_valid;
		logic [IndexW-1:0] group_idx;
		logic [ExcW-1:0]   exc_word;
		logic [ByteW-1:0]  bases;
	} byte_result_t;

	// typed = 1: gives/bases are written in by hand, else the predictor decides
	typedef struct packed {
		logic [SymW-1:0]  sym;
		logic             typed;
		logic             gives;
		logic [ByteW-1:0] bases;
	} dir_row_t;

	localparam dir_row_t DIRECTED_ROWS [DirRows] = '{
		'{ChA,            1'b1, 1'b0, 8'h00},
		'{ChC,            1'b1, 1'b0, 8'h00},
		'{ChG,            1'b1, 1'b0, 8'h00},
		'{ChT,            1'b1, 1'b1, 8'h1B},
		'{ChA | LowerBit, 1'b1, 1'b0, 8'h00},
		'{ChC | LowerBit, 1'b1, 1'b0, 8'h00},
		'{ChG | LowerBit, 1'b1, 1'b0, 8'h00},
		'{ChT | LowerBit, 1'b1, 1'b1, 8'h1B},
		'{ChT,            1'b1, 1'b0, 8'h00},
		'{ChT | LowerBit, 1'b1, 1'b0, 8'h00},
		'{ChT,            1'b1, 1'b0, 8'h00},
		'{ChT | LowerBit, 1'b1, 1'b1, 8'hFF},
		'{8'h00,          1'b1, 1'b0, 8'h00},
		'{8'hFF,          1'b1, 1'b0, 8'h00},
		'{8'h4E,          1'b1, 1'b0, 8'h00},
		'{8'h6E,          1'b1, 1'b1, 8'h00},
		'{ChA | HighBit,  1'b0, 1'b0, 8'h00},
		'{8'h01,          1'b0, 1'b0, 8'h00},
		'{ChC | LowerBit, 1'b0, 1'b0, 8'h00},
		'{ChG | HighBit,  1'b0, 1'b0, 8'h00},
		'{ChG,            1'b1, 1'b0, 8'h00},
		'{ChA,            1'b1, 1'b0, 8'h00},
		'{ChT,            1'b1, 1'b0, 8'h00},
		'{ChC,            1'b1, 1'b1, 8'h8D}
	};

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [SymW-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [TdataW-1:0] m_axis_tdata;
	logic [UserW-1:0]  m_axis_tuser;

	nucleotide_packer_with_exception_mask DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predictor state
	logic [5:0]        pend_codes;
	logic [ExcW-2:0]   pend_exc;
	logic [CountW-1:0] sym_count;

	byte_result_t awaited_bytes[$];
	int unsigned  fail_count;
	int unsigned  src_idle_pct;
	int unsigned  sink_stall_pct;
	int unsigned  hold_seq;
	int unsigned  stuck_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void flag_error(string what, logic [TdataW-1:0] want,
		logic [TdataW-1:0] got);
		if (fail_count < MaxReports)
			$display("mismatch %s: expected %h, got %h", what, want, got);
		fail_count++;
	endfunction

	// Returns 1 when this symbol closes a byte; res then holds the word it causes.
	function automatic bit pack_symbol(input logic [SymW-1:0] sym, output byte_result_t res);
		logic [SymW-1:0]  folded;
		logic [CodeW-1:0] code;
		logic             bad;
		logic [ByteW-1:0] codes;
		logic [ExcW-1:0]  bits;
		bit               byte_done;
		bit               word_done;
		folded = sym & FoldMask;
		bad    = 1'b0;
		code   = CodeA;
		if (folded == ChC)
			code = CodeC;
		else if (folded == ChG)
			code = CodeG;
		else if (folded == ChT)
			code = CodeT;
		else if (folded != ChA)
			bad = 1'b1;
		codes     = {pend_codes, code};
		bits      = {pend_exc, bad};
		byte_done = (sym_count[1:0] == 2'b11);
		word_done = (sym_count[GroupBits-1:0] == GroupBits'(GroupSize - 1));
		res            = '0;
		res.byte_valid = 1'b1;
		res.bases      = codes;
		// all-clean groups report nothing beyond the byte
		if (word_done && bits != '0) begin
			res.word_valid = 1'b1;
			res.exc_word   = bits;
			res.group_idx  = sym_count[CountW-1:GroupBits];
		end
		pend_codes = byte_done ? 6'd0 : codes[5:0];
		pend_exc   = word_done ? '0 : bits[ExcW-2:0];
		sym_count  = sym_count + CountW'(1);
		return byte_done;
	endfunction

	function automatic logic [SymW-1:0] random_base();
		logic [SymW-1:0] b;
		case ($urandom_range(0, 3))
			0: b = ChA;
			1: b = ChC;
			2: b = ChG;
			default: b = ChT;
		endcase
		if ($urandom_range(0, 1) == 1)
			b = b | LowerBit;
		return b;
	endfunction

	function automatic logic [SymW-1:0] random_symbol(group_mode_t mode);
		logic [SymW-1:0] s;
		s = random_base();
		case (mode)
			GRP_SPARSE: begin
				if ($urandom_range(0, 15) == 0)
					s = SymW'($urandom_range(0, 255));
			end
			GRP_NOISE: begin
				case ($urandom_range(0, 2))
					0: s = SymW'($urandom_range(0, 255));
					1: s = s | HighBit;   // near miss: letter with bit 7 set
					default: ;
				endcase
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic send_symbol(input logic [SymW-1:0] sym);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// receiver: random back-pressure plus a long hold-off on request
	initial begin : sink
		int unsigned hold_left;
		int unsigned seen_seq;
		hold_left     = 0;
		seen_seq      = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq  = hold_seq;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : monitor
		byte_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_bytes.size() == 0) begin
				flag_error("unexpected word", '0, m_axis_tdata);
			end else begin
				want = awaited_bytes.pop_front();
				if (m_axis_tuser[0] !== want.byte_valid)
					flag_error("byte_valid", TdataW'(want.byte_valid),
						TdataW'(m_axis_tuser[0]));
				if (m_axis_tuser[1] !== want.word_valid)
					flag_error("word_valid", TdataW'(want.word_valid),
						TdataW'(m_axis_tuser[1]));
				if (m_axis_tdata[ByteW-1:0] !== want.bases)
					flag_error("packed_byte", TdataW'(want.bases),
						TdataW'(m_axis_tdata[ByteW-1:0]));
				if (m_axis_tdata[ByteW+ExcW-1:ByteW] !== want.exc_word)
					flag_error("exception_word", TdataW'(want.exc_word),
						TdataW'(m_axis_tdata[ByteW+ExcW-1:ByteW]));
				if (m_axis_tdata[DataW-1:ByteW+ExcW] !== want.group_idx)
					flag_error("word_index", TdataW'(want.group_idx),
						TdataW'(m_axis_tdata[DataW-1:ByteW+ExcW]));
				if (m_axis_tdata[TdataW-1:DataW] !== '0)
					flag_error("tdata padding", '0,
						TdataW'(m_axis_tdata[TdataW-1:DataW]));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= StuckLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		byte_result_t res;
		dir_row_t     row;
		group_mode_t  mode;
		logic [SymW-1:0] sym;
		bit           made;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		pend_codes     = '0;
		pend_exc       = '0;
		sym_count      = '0;
		fail_count     = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_seq       = 0;
		mode           = GRP_NOISE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DirRows; i++) begin
			row = DIRECTED_ROWS[i];
			send_symbol(row.sym);
			made = pack_symbol(row.sym, res);
			if (row.typed) begin
				if (row.gives) begin
					res            = '0;
					res.byte_valid = 1'b1;
					res.bases      = row.bases;
					awaited_bytes.push_back(res);
				end
			end else if (made) begin
				awaited_bytes.push_back(res);
			end
		end

		// phases: none idle, sender idle, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = (ph == 1) ? 45 : (ph == 3) ? 33 : 0;
			sink_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 33 : 0;
			for (int n = 0; n < RandPerPhase; n++) begin
				if (ph == 0 && n == 200)
					hold_seq <= hold_seq + 1;   // long hold-off, sender keeps going
				if (sym_count[GroupBits-1:0] == '0) begin
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4, 5, 6: mode = GRP_CLEAN;
						7, 8, 9, 10, 11, 12, 13, 14: mode = GRP_SPARSE;
						default: mode = GRP_NOISE;
					endcase
				end
				sym = random_symbol(mode);
				send_symbol(sym);
				if (pack_symbol(sym, res))
					awaited_bytes.push_back(res);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (awaited_bytes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && awaited_bytes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
